// File: hw/rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

  // Sizes of the stores and of the power tables
  localparam int POOL_DEPTH      = 64;
  localparam int CONFIG_SLOTS    = 8;
  localparam int POW_TABLE_DEPTH = 256;

  localparam int PIDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int SIDX_W = (CONFIG_SLOTS > 1) ? $clog2(CONFIG_SLOTS) : 1;
  localparam int TCNT_W = $clog2(CONFIG_SLOTS + 1);
  localparam int TIDX_W = $clog2(POW_TABLE_DEPTH + 1);
  localparam int TAB_W  = 18;

  typedef enum logic [1:0] {
    ACT_CONFIG = 2'd0,
    ACT_SPAWN  = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Datapath commands issued by the controller
  typedef enum logic [4:0] {
    C_NONE, C_LATCH, C_EXEC,
    C_T_RD, C_T_EVAL, C_T_MOVE,
    C_P_G, C_P_LA, C_P_LM, C_P_LR, C_P_QM, C_P_QR, C_P_EA, C_P_EM, C_P_ER,
    C_P_VX, C_P_VY, C_P_PX, C_P_PY, C_P_PW,
    C_O_RD, C_O_LD, C_O_EMPTY
  } cmd_t;

  typedef struct packed {
    logic more;    // scan index below pool count
    logic dead;    // particle just read has run out of life
    logic empty;   // pool holds no particle
    logic k_last;  // report index is the last particle
  } dp_status_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        life;
    logic [2:0]         slot;
  } part_t;

  typedef logic [TAB_W-1:0] tab_t [POW_TABLE_DEPTH+1];

  // Fractional log2 of a Q16 mantissa in [1,2], by repeated squaring
  function automatic logic [16:0] log2_frac(input logic [17:0] x);
    logic [63:0] y;
    logic [16:0] r;
    y = 64'(x);
    r = '0;
    if (x >= 18'd131072) return 17'd65536;
    if (x < 18'd65536) return '0;
    for (int i = 1; i <= 16; i++) begin
      y = (y * y) >> 16;
      if (y >= 64'd131072) begin
        y = y >> 1;
        r[16-i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic tab_t build_log_tab();
    tab_t        t;
    logic [17:0] frac;
    for (int k = 0; k <= POW_TABLE_DEPTH; k++) begin
      frac = 18'((longint'(k) * 65536) / POW_TABLE_DEPTH);
      t[k] = TAB_W'(log2_frac(18'd65536 + frac));
    end
    return t;
  endfunction

  // Smallest mantissa whose log2 fraction reaches each table point
  function automatic tab_t build_exp_tab();
    tab_t        t;
    logic [16:0] frac;
    logic [17:0] lo;
    logic [17:0] hi;
    logic [17:0] mid;
    for (int k = 0; k <= POW_TABLE_DEPTH; k++) begin
      frac = 17'((longint'(k) * 65536) / POW_TABLE_DEPTH);
      lo = 18'd65536;
      hi = 18'd131072;
      while (lo < hi) begin
        mid = 18'((19'(lo) + 19'(hi)) >> 1);
        if (log2_frac(mid) >= frac) hi = mid;
        else lo = mid + 18'd1;
      end
      t[k] = TAB_W'(lo);
    end
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_log_tab();
  localparam tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// File: hw/rtl/particle_pool_physics_step_unit.sv
// Channel   Handshake                 Payload
// item      item_valid / item_ready   action, gravity ... dt
// result    res_valid / res_ready     config_slot ... last
//
// add_config, spawn and clear are latched and then executed, with any wait for the result register.
// tick runs each surviving particle through the physics states (one shared 33x18
// multiplier, eight products in sequence), each removed particle through read, evaluate and move,
// then reports each particle through the single pool read port.
// Synchronous reset empties the pool and the config table; entries are not cleared.
// A stalled result holds; the next item is taken while it waits.
`default_nettype none

module particle_pool_physics_step_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] gravity,
  input  logic [16:0]        damping,
  input  logic [15:0]        streak_length,
  input  logic               draw_mode,
  input  logic signed [31:0] spawn_x,
  input  logic signed [31:0] spawn_y,
  input  logic signed [31:0] spawn_vx,
  input  logic signed [31:0] spawn_vy,
  input  logic [30:0]        spawn_life,
  input  logic [2:0]         spawn_config,
  input  logic [15:0]        dt,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [2:0]         config_slot,
  output logic               table_full,
  output logic               accepted,
  output logic               particle_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [30:0]        out_life,
  output logic [2:0]         out_config,
  output logic [6:0]         live_count,
  output logic               last
);
  import pps_pkg::*;

  cmd_t       cmd;
  dp_status_t status;

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .action     (action),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pps_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .action         (action),
    .gravity        (gravity),
    .damping        (damping),
    .streak_length  (streak_length),
    .draw_mode      (draw_mode),
    .spawn_x        (spawn_x),
    .spawn_y        (spawn_y),
    .spawn_vx       (spawn_vx),
    .spawn_vy       (spawn_vy),
    .spawn_life     (spawn_life),
    .spawn_config   (spawn_config),
    .dt             (dt),
    .config_slot    (config_slot),
    .table_full     (table_full),
    .accepted       (accepted),
    .particle_valid (particle_valid),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_life       (out_life),
    .out_config     (out_config),
    .live_count     (live_count),
    .last           (last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/pps_ctrl.sv
`default_nettype none

module pps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [1:0]          action,
  output logic                res_valid,
  input  logic                res_ready,
  input  pps_pkg::dp_status_t status,
  output pps_pkg::cmd_t       cmd
);
  import pps_pkg::*;

  typedef enum logic [21:0] {
    ST_IDLE    = 22'h000001,
    ST_EXEC    = 22'h000002,
    ST_T_RD    = 22'h000004,
    ST_T_EVAL  = 22'h000008,
    ST_T_MOVE  = 22'h000010,
    ST_P_G     = 22'h000020,
    ST_P_LA    = 22'h000040,
    ST_P_LM    = 22'h000080,
    ST_P_LR    = 22'h000100,
    ST_P_QM    = 22'h000200,
    ST_P_QR    = 22'h000400,
    ST_P_EA    = 22'h000800,
    ST_P_EM    = 22'h001000,
    ST_P_ER    = 22'h002000,
    ST_P_VX    = 22'h004000,
    ST_P_VY    = 22'h008000,
    ST_P_PX    = 22'h010000,
    ST_P_PY    = 22'h020000,
    ST_P_PW    = 22'h040000,
    ST_O_RD    = 22'h080000,
    ST_O_LD    = 22'h100000,
    ST_O_EMPTY = 22'h200000
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_valid_next;
  logic   out_free;
  logic   load;

  assign out_free = !res_valid || res_ready;

  // Sequence the actions
  always_comb begin
    state_next = state;
    cmd        = C_NONE;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd        = C_LATCH;
          state_next = (action == ACT_TICK) ? ST_T_RD : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd        = C_EXEC;
          state_next = ST_IDLE;
        end
      end
      ST_T_RD: begin
        cmd        = C_T_RD;
        state_next = status.more ? ST_T_EVAL : ST_O_RD;
      end
      ST_T_EVAL: begin
        cmd        = C_T_EVAL;
        state_next = status.dead ? ST_T_MOVE : ST_P_G;
      end
      ST_T_MOVE: begin cmd = C_T_MOVE; state_next = ST_T_RD;  end
      ST_P_G:    begin cmd = C_P_G;    state_next = ST_P_LA;  end
      ST_P_LA:   begin cmd = C_P_LA;   state_next = ST_P_LM;  end
      ST_P_LM:   begin cmd = C_P_LM;   state_next = ST_P_LR;  end
      ST_P_LR:   begin cmd = C_P_LR;   state_next = ST_P_QM;  end
      ST_P_QM:   begin cmd = C_P_QM;   state_next = ST_P_QR;  end
      ST_P_QR:   begin cmd = C_P_QR;   state_next = ST_P_EA;  end
      ST_P_EA:   begin cmd = C_P_EA;   state_next = ST_P_EM;  end
      ST_P_EM:   begin cmd = C_P_EM;   state_next = ST_P_ER;  end
      ST_P_ER:   begin cmd = C_P_ER;   state_next = ST_P_VX;  end
      ST_P_VX:   begin cmd = C_P_VX;   state_next = ST_P_VY;  end
      ST_P_VY:   begin cmd = C_P_VY;   state_next = ST_P_PX;  end
      ST_P_PX:   begin cmd = C_P_PX;   state_next = ST_P_PY;  end
      ST_P_PY:   begin cmd = C_P_PY;   state_next = ST_P_PW;  end
      ST_P_PW:   begin cmd = C_P_PW;   state_next = ST_T_RD;  end
      ST_O_RD: begin
        cmd        = C_O_RD;
        state_next = status.empty ? ST_O_EMPTY : ST_O_LD;
      end
      ST_O_LD: begin
        if (out_free) begin
          cmd        = C_O_LD;
          state_next = status.k_last ? ST_IDLE : ST_O_RD;
        end else begin
          cmd = C_O_RD;
        end
      end
      ST_O_EMPTY: begin
        if (out_free) begin
          cmd        = C_O_EMPTY;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold a result until it is taken
  assign load = (cmd == C_EXEC) || (cmd == C_O_LD) || (cmd == C_O_EMPTY);
  assign res_valid_next = load || (res_valid && !res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pps_dp.sv
`default_nettype none

module pps_dp (
  input  logic                clk,
  input  logic                rst,
  input  pps_pkg::cmd_t       cmd,
  output pps_pkg::dp_status_t status,
  input  logic [1:0]          action,
  input  logic signed [31:0]  gravity,
  input  logic [16:0]         damping,
  input  logic [15:0]         streak_length,
  input  logic                draw_mode,
  input  logic signed [31:0]  spawn_x,
  input  logic signed [31:0]  spawn_y,
  input  logic signed [31:0]  spawn_vx,
  input  logic signed [31:0]  spawn_vy,
  input  logic [30:0]         spawn_life,
  input  logic [2:0]          spawn_config,
  input  logic [15:0]         dt,
  output logic [2:0]          config_slot,
  output logic                table_full,
  output logic                accepted,
  output logic                particle_valid,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic [30:0]         out_life,
  output logic [2:0]          out_config,
  output logic [6:0]          live_count,
  output logic                last
);
  import pps_pkg::*;

  localparam int LK_W = 17 + TIDX_W;

  // Latched input item
  action_t            act_r;
  logic signed [31:0] grav_in;
  logic [16:0]        damp_in;
  logic [15:0]        streak_in;
  logic               mode_in;
  part_t              spawn_r;
  logic [15:0]        dt_r;

  // Pool store and counters
  part_t              mem [POOL_DEPTH];
  part_t              rdata;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   last_idx;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   k;
  logic               mem_we;
  logic [PIDX_W-1:0]  mem_waddr;
  logic [PIDX_W-1:0]  mem_raddr;
  part_t              mem_wdata;

  // Config table
  logic signed [31:0] tab_grav   [CONFIG_SLOTS];
  logic [16:0]        tab_damp   [CONFIG_SLOTS];
  logic [15:0]        tab_streak [CONFIG_SLOTS];
  logic               tab_mode   [CONFIG_SLOTS];
  logic [TCNT_W-1:0]  tcount;
  logic               hit;
  logic [SIDX_W-1:0]  hit_idx;
  logic [SIDX_W-1:0]  slot_eff;

  // Physics working registers
  part_t              cur;
  logic signed [31:0] grav_c;
  logic [16:0]        damp_c;
  logic [3:0]         e_r;
  logic [15:0]        g1_r;
  logic signed [31:0] vy1;
  logic [TAB_W-1:0]   la;
  logic [TAB_W-1:0]   ldiff;
  logic               ldown;
  logic [15:0]        lfr;
  logic [16:0]        lf;
  logic               nbig;
  logic [3:0]         n_r;
  logic [15:0]        r_r;
  logic [16:0]        f_r;
  logic signed [31:0] vx2;
  logic signed [31:0] vy2;
  logic signed [31:0] pxn;

  // Shared multiplier
  logic signed [32:0] ma;
  logic signed [17:0] mb;
  logic signed [50:0] prod;

  // Combinational helpers
  logic [3:0]         msb;
  logic [15:0]        norm;
  logic [16:0]        g_in;
  logic [LK_W-1:0]    pmul;
  logic [TIDX_W-1:0]  lidx;
  logic [TIDX_W-1:0]  ia;
  logic [TIDX_W-1:0]  ib;
  logic               lk_over;
  logic [TAB_W-1:0]   ta;
  logic [TAB_W-1:0]   tb;
  logic [TAB_W-1:0]   ires;
  logic [20:0]        neg;
  logic [16:0]        f_calc;
  logic signed [31:0] pyn;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [34:0] b);
    logic signed [35:0] s;
    s = $signed({{4{a[31]}}, a}) + $signed({b[34], b});
    if (s > $signed(36'h0_7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (s < $signed(36'hF_8000_0000)) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  assign last_idx = count - CNT_W'(1);

  // Status back to the controller
  assign status.more   = (i < count);
  assign status.dead   = (rdata.life <= 31'(dt_r));
  assign status.empty  = (count == '0);
  assign status.k_last = (k == last_idx);

  // Search the config table, lowest matching slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int s = CONFIG_SLOTS - 1; s >= 0; s--) begin
      if ((TCNT_W'(s) < tcount) && (tab_grav[s] == grav_in) &&
          (tab_damp[s] == damp_in) && (tab_streak[s] == streak_in) &&
          (tab_mode[s] == mode_in)) begin
        hit     = 1'b1;
        hit_idx = SIDX_W'(s);
      end
    end
  end

  // Map an out-of-range particle slot to slot 0
  assign slot_eff = (4'(rdata.slot) < 4'(CONFIG_SLOTS)) ? rdata.slot[SIDX_W-1:0] : '0;

  // Normalize damping for the log lookup
  always_comb begin
    msb = '0;
    for (int b = 0; b < 16; b++) begin
      if (damp_c[b]) msb = 4'(b);
    end
    norm = damp_c[15:0] << (4'd15 - msb);
  end

  // Table lookup for log2 or exp2 interpolation
  always_comb begin
    g_in    = (cmd == C_P_EA) ? (17'd65536 - {1'b0, r_r}) : {1'b0, g1_r};
    pmul    = LK_W'(g_in) * LK_W'(POW_TABLE_DEPTH);
    lidx    = pmul[16 +: TIDX_W];
    lk_over = (lidx >= TIDX_W'(POW_TABLE_DEPTH));
    ia      = lk_over ? TIDX_W'(POW_TABLE_DEPTH) : lidx;
    ib      = lk_over ? TIDX_W'(POW_TABLE_DEPTH) : lidx + TIDX_W'(1);
    ta      = (cmd == C_P_EA) ? EXP_TAB[ia] : LOG_TAB[ia];
    tb      = (cmd == C_P_EA) ? EXP_TAB[ib] : LOG_TAB[ib];
  end

  // Finish the interpolation from the product
  assign ires = ldown ? (la - prod[16 +: TAB_W]) : (la + prod[16 +: TAB_W]);

  // Negated log2 of damping, Q16
  assign neg = {5'd16 - {1'b0, e_r}, 16'h0000} - 21'(lf);

  // Pick the power result, special cases first
  always_comb begin
    if ((dt_r == '0) || (damp_c >= 17'd65536)) f_calc = 17'd65536;
    else if (damp_c == '0)                      f_calc = '0;
    else if (nbig)                              f_calc = '0;
    else if (r_r == '0)                         f_calc = 17'd65536 >> n_r;
    else f_calc = 17'(ires >> (5'({1'b0, n_r}) + 5'd1));
  end

  assign pyn = sat_add(cur.py, prod[50:16]);

  // Select multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd)
      C_P_G: begin
        ma = {grav_c[31], grav_c};
        mb = $signed({2'b00, dt_r});
      end
      C_P_LM, C_P_EM: begin
        ma = $signed({{(33 - TAB_W){1'b0}}, ldiff});
        mb = $signed({2'b00, lfr});
      end
      C_P_QM: begin
        ma = $signed({12'h000, neg});
        mb = $signed({2'b00, dt_r});
      end
      C_P_VX: begin
        ma = {cur.vx[31], cur.vx};
        mb = $signed({1'b0, f_r});
      end
      C_P_VY: begin
        ma = {vy1[31], vy1};
        mb = $signed({1'b0, f_r});
      end
      C_P_PX: begin
        ma = {vx2[31], vx2};
        mb = $signed({2'b00, dt_r});
      end
      C_P_PY: begin
        ma = {vy2[31], vy2};
        mb = $signed({2'b00, dt_r});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // Pool store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i[PIDX_W-1:0];
    mem_wdata = rdata;
    mem_raddr = i[PIDX_W-1:0];
    case (cmd)
      C_EXEC: begin
        mem_we    = (act_r == ACT_SPAWN) && (count < CNT_W'(POOL_DEPTH));
        mem_waddr = count[PIDX_W-1:0];
        mem_wdata = spawn_r;
      end
      C_T_EVAL: mem_raddr = last_idx[PIDX_W-1:0];
      C_T_MOVE: mem_we = 1'b1;
      C_P_PW: begin
        mem_we    = 1'b1;
        mem_wdata = '{px: pxn, py: pyn, vx: vx2, vy: vy2,
                      life: cur.life - 31'(dt_r), slot: cur.slot};
      end
      C_O_RD, C_O_LD: mem_raddr = k[PIDX_W-1:0];
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // Counters and tables
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      tcount <= '0;
      i      <= '0;
      k      <= '0;
    end else begin
      case (cmd)
        C_LATCH: begin
          i <= '0;
          k <= '0;
        end
        C_EXEC: begin
          unique case (act_r)
            ACT_CONFIG: begin
              if (!hit && (tcount < TCNT_W'(CONFIG_SLOTS))) begin
                tab_grav[tcount[SIDX_W-1:0]]   <= grav_in;
                tab_damp[tcount[SIDX_W-1:0]]   <= damp_in;
                tab_streak[tcount[SIDX_W-1:0]] <= streak_in;
                tab_mode[tcount[SIDX_W-1:0]]   <= mode_in;
                tcount <= tcount + TCNT_W'(1);
              end
            end
            ACT_SPAWN: begin
              if (count < CNT_W'(POOL_DEPTH)) count <= count + CNT_W'(1);
            end
            ACT_TICK: count <= count;
            ACT_CLEAR: begin
              count  <= '0;
              tcount <= '0;
            end
            default: count <= count;
          endcase
        end
        C_T_MOVE: count <= last_idx;
        C_P_PW:   i <= i + CNT_W'(1);
        C_O_LD:   k <= k + CNT_W'(1);
        default:  count <= count;
      endcase
    end
  end

  // Item latch and physics registers
  always_ff @(posedge clk) begin
    case (cmd)
      C_LATCH: begin
        act_r     <= action_t'(action);
        grav_in   <= gravity;
        damp_in   <= damping;
        streak_in <= streak_length;
        mode_in   <= draw_mode;
        spawn_r   <= '{px: spawn_x, py: spawn_y, vx: spawn_vx, vy: spawn_vy,
                       life: spawn_life, slot: spawn_config};
        dt_r      <= dt;
      end
      C_T_EVAL: begin
        cur    <= rdata;
        grav_c <= tab_grav[slot_eff];
        damp_c <= tab_damp[slot_eff];
      end
      C_P_G: begin
        e_r  <= msb;
        g1_r <= {norm[14:0], 1'b0};
      end
      C_P_LA, C_P_EA: begin
        if (cmd == C_P_LA) vy1 <= sat_add(cur.vy, prod[50:16]);
        la    <= ta;
        ldown <= (tb < ta);
        ldiff <= (tb < ta) ? (ta - tb) : (tb - ta);
        lfr   <= pmul[15:0];
      end
      C_P_LR: lf <= ires[16:0];
      C_P_QR: begin
        nbig <= |prod[50:36];
        n_r  <= prod[35:32];
        r_r  <= prod[31:16];
      end
      C_P_ER: f_r <= f_calc;
      C_P_VY: vx2 <= prod[47:16];
      C_P_PX: vy2 <= prod[47:16];
      C_P_PY: pxn <= sat_add(cur.px, prod[50:16]);
      default: f_r <= f_r;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    case (cmd)
      C_EXEC: begin
        config_slot    <= '0;
        table_full     <= 1'b0;
        accepted       <= 1'b0;
        particle_valid <= 1'b0;
        out_x          <= '0;
        out_y          <= '0;
        out_life       <= '0;
        out_config     <= '0;
        last           <= 1'b1;
        live_count     <= 7'(count);
        unique case (act_r)
          ACT_CONFIG: begin
            if (hit) config_slot <= 3'(hit_idx);
            else if (tcount >= TCNT_W'(CONFIG_SLOTS)) table_full <= 1'b1;
            else config_slot <= 3'(tcount);
          end
          ACT_SPAWN: begin
            if (count < CNT_W'(POOL_DEPTH)) begin
              accepted   <= 1'b1;
              live_count <= 7'(count + CNT_W'(1));
            end
          end
          ACT_TICK:  live_count <= 7'(count);
          ACT_CLEAR: live_count <= '0;
          default:   live_count <= 7'(count);
        endcase
      end
      C_O_LD: begin
        config_slot    <= '0;
        table_full     <= 1'b0;
        accepted       <= 1'b0;
        particle_valid <= 1'b1;
        out_x          <= rdata.px;
        out_y          <= rdata.py;
        out_life       <= rdata.life;
        out_config     <= rdata.slot;
        live_count     <= 7'(count);
        last           <= (k == last_idx);
      end
      C_O_EMPTY: begin
        config_slot    <= '0;
        table_full     <= 1'b0;
        accepted       <= 1'b0;
        particle_valid <= 1'b0;
        out_x          <= '0;
        out_y          <= '0;
        out_life       <= '0;
        out_config     <= '0;
        live_count     <= 7'(count);
        last           <= 1'b1;
      end
      default: last <= last;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/pps_checker.sv
`default_nettype none

module pps_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [2:0]         config_slot,
  input logic               table_full,
  input logic               accepted,
  input logic               particle_valid,
  input logic signed [31:0] out_x,
  input logic [30:0]        out_life,
  input logic [6:0]         live_count,
  input logic               last
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_x) && $stable(last))
    else $error("stalled result changed");

  // Only a particle report may be followed by more results of the same item
  a_more: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> particle_valid)
    else $error("non-final result without particle");

  // Full table answers slot zero only, with no accepted spawn and no particle
  a_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && table_full |-> config_slot == 3'd0 && !accepted && !particle_valid)
    else $error("bad full-table result");

  // A survivor always has life left
  a_life: assert property (@(posedge clk) disable iff (rst)
    res_valid && particle_valid |-> out_life != 31'd0 && live_count != 7'd0)
    else $error("survivor without life");

  // A stored spawn leaves a nonempty pool
  a_spawn: assert property (@(posedge clk) disable iff (rst)
    res_valid && accepted |-> live_count != 7'd0 && last)
    else $error("accepted spawn with empty pool");

endmodule

bind particle_pool_physics_step_unit pps_checker u_chk (.*);

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;
  import pps_pkg::*;

  localparam int NPOOL = POOL_DEPTH;
  localparam int NSLOT = CONFIG_SLOTS;
  localparam int NTAB  = POW_TABLE_DEPTH;

  typedef struct {
    action_t     act;
    logic [31:0] grav;
    logic [16:0] damp;
    logic [15:0] streak;
    logic        mode;
    logic [31:0] sx, sy, svx, svy;
    logic [30:0] life;
    logic [2:0]  cfg;
    logic [15:0] dt;
  } item_t;

  typedef struct {
    logic [2:0]  slot;
    logic        full;
    logic        acc;
    logic        valid;
    logic [31:0] x, y;
    logic [30:0] life;
    logic [2:0]  cfg;
    logic [6:0]  count;
    logic        last;
  } result_t;

  logic clk, rst;
  logic item_valid, item_ready, res_valid, res_ready;
  logic [1:0] action;
  logic signed [31:0] gravity, spawn_x, spawn_y, spawn_vx, spawn_vy, out_x, out_y;
  logic [16:0] damping;
  logic [15:0] streak_length, dt;
  logic draw_mode, table_full, accepted, particle_valid, last;
  logic [30:0] spawn_life, out_life;
  logic [2:0] spawn_config, config_slot, out_config;
  logic [6:0] live_count;

  particle_pool_physics_step_unit DUT (.*);

  // shadow copy of the pool and config table
  longint      pos_x [NPOOL], pos_y [NPOOL], vel_x [NPOOL], vel_y [NPOOL];
  longint      life_left [NPOOL];
  int          part_slot [NPOOL];
  int          pool_n, cfg_n, cfg_written;
  logic [31:0] cfg_grav [NSLOT];
  logic [16:0] cfg_damp [NSLOT];
  logic [15:0] cfg_streak [NSLOT];
  logic        cfg_mode [NSLOT];
  longint      log_lut [NTAB+1], exp_lut [NTAB+1];

  item_t   item_q [$];
  result_t result_q [$];
  int      errors, n_items, n_results, n_ticks, n_drops, n_full;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint frac_log2(longint x);
    longint y;
    longint r;
    y = x;
    r = 0;
    if (x >= 131072) return 65536;
    if (x < 65536) return 0;
    for (int i = 1; i <= 16; i++) begin
      y = (y * y) >> 16;
      if (y >= 131072) begin
        y = y >> 1;
        r |= longint'(1) << (16 - i);
      end
    end
    return r;
  endfunction

  function automatic longint lerp(bit use_exp, longint g);
    longint p, idx, fr, a, b;
    p = g * NTAB;
    idx = p >> 16;
    fr = p & 16'hFFFF;
    if (idx >= NTAB) return use_exp ? exp_lut[NTAB] : log_lut[NTAB];
    a = use_exp ? exp_lut[idx] : log_lut[idx];
    b = use_exp ? exp_lut[idx+1] : log_lut[idx+1];
    if (b >= a) return a + (((b - a) * fr) >> 16);
    return a - (((a - b) * fr) >> 16);
  endfunction

  // damping raised to dt, Q16
  function automatic longint damp_pow(longint d, longint t);
    int e;
    longint lf, neg, q, n, r;
    e = 15;
    if (t == 0 || d >= 65536) return 65536;
    if (d == 0) return 0;
    while (((d >> e) & 1) == 0) e--;
    lf = lerp(0, (d << (16 - e)) - 65536);
    neg = longint'(16 - e) * 65536 - lf;
    q = (t * neg) >> 16;
    n = q >> 16;
    r = q & 16'hFFFF;
    if (n > 15) return 0;
    if (r == 0) return 65536 >> n;
    return lerp(1, 65536 - r) >> (n + 1);
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic result_t blank_result();
    result_t r;
    r = '{default: '0};
    r.last = 1'b1;
    return r;
  endfunction

  // advance the shadow state by one item and queue what it should produce
  task automatic queue_item(item_t it);
    result_t r;
    int      i, l, c;
    bit      hit;
    longint  g, f, vx, vy, t;
    r = blank_result();
    item_q.push_back(it);
    case (it.act)
      ACT_CONFIG: begin
        hit = 0;
        for (i = 0; i < cfg_n; i++)
          if (!hit && cfg_grav[i] == it.grav && cfg_damp[i] == it.damp &&
              cfg_streak[i] == it.streak && cfg_mode[i] == it.mode) begin
            r.slot = 3'(i);
            hit = 1;
          end
        if (!hit) begin
          if (cfg_n >= NSLOT) begin
            r.full = 1;
            n_full++;
          end else begin
            cfg_grav[cfg_n] = it.grav;
            cfg_damp[cfg_n] = it.damp;
            cfg_streak[cfg_n] = it.streak;
            cfg_mode[cfg_n] = it.mode;
            r.slot = 3'(cfg_n);
            cfg_n++;
            if (cfg_n > cfg_written) cfg_written = cfg_n;
          end
        end
        r.count = 7'(pool_n);
        result_q.push_back(r);
      end
      ACT_SPAWN: begin
        if (pool_n < NPOOL) begin
          pos_x[pool_n] = longint'(signed'(it.sx));
          pos_y[pool_n] = longint'(signed'(it.sy));
          vel_x[pool_n] = longint'(signed'(it.svx));
          vel_y[pool_n] = longint'(signed'(it.svy));
          life_left[pool_n] = it.life;
          part_slot[pool_n] = it.cfg;
          pool_n++;
          r.acc = 1;
        end else n_drops++;
        r.count = 7'(pool_n);
        result_q.push_back(r);
      end
      ACT_TICK: begin
        n_ticks++;
        t = it.dt;
        i = 0;
        while (i < pool_n) begin
          if (life_left[i] <= t) begin
            // swap the last particle into the hole
            l = pool_n - 1;
            pos_x[i] = pos_x[l];
            pos_y[i] = pos_y[l];
            vel_x[i] = vel_x[l];
            vel_y[i] = vel_y[l];
            life_left[i] = life_left[l];
            part_slot[i] = part_slot[l];
            pool_n = l;
          end else begin
            c = part_slot[i];
            g = longint'(signed'(cfg_grav[c]));
            f = damp_pow(cfg_damp[c], t);
            vy = sat(vel_y[i] + ((g * t) >>> 16));
            vx = (vel_x[i] * f) >>> 16;
            vy = (vy * f) >>> 16;
            vel_x[i] = vx;
            vel_y[i] = vy;
            pos_x[i] = sat(pos_x[i] + ((vx * t) >>> 16));
            pos_y[i] = sat(pos_y[i] + ((vy * t) >>> 16));
            life_left[i] -= t;
            i++;
          end
        end
        if (pool_n == 0) result_q.push_back(r);
        for (i = 0; i < pool_n; i++) begin
          r = blank_result();
          r.valid = 1;
          r.x = pos_x[i][31:0];
          r.y = pos_y[i][31:0];
          r.life = life_left[i][30:0];
          r.cfg = 3'(part_slot[i]);
          r.count = 7'(pool_n);
          r.last = (i == pool_n - 1);
          result_q.push_back(r);
        end
      end
      default: begin
        pool_n = 0;
        cfg_n = 0;
        result_q.push_back(r);
      end
    endcase
  endtask

  function automatic item_t noise_item(action_t a);
    item_t it;
    it.act = a;
    it.grav = $urandom;
    it.damp = 17'($urandom_range(0, 131071));
    it.streak = 16'($urandom);
    it.mode = 1'($urandom);
    it.sx = $urandom;
    it.sy = $urandom;
    it.svx = $urandom;
    it.svy = $urandom;
    it.life = 31'($urandom_range(1, 32'h7FFF_FFFF));
    it.cfg = 3'($urandom);
    it.dt = 16'($urandom);
    return it;
  endfunction

  // only slots that were ever written are given to spawned particles
  function automatic logic [2:0] pick_slot();
    return 3'($urandom_range(0, cfg_written - 1));
  endfunction

  function automatic item_t rand_config();
    item_t it;
    it = noise_item(ACT_CONFIG);
    case ($urandom_range(0, 5))
      0: it.damp = 0;
      1: it.damp = 65536;
      2: it.damp = 17'($urandom_range(65537, 131071));
      3: it.damp = 17'($urandom_range(50000, 65535));
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) it.grav = $signed($urandom_range(0, 1200000)) - 600000;
    if ($urandom_range(0, 3) == 0 && cfg_n > 0) begin
      // repeat a stored config to hit the lookup
      it.grav = cfg_grav[0];
      it.damp = cfg_damp[0];
      it.streak = cfg_streak[0];
      it.mode = cfg_mode[0];
    end
    return it;
  endfunction

  function automatic item_t rand_spawn();
    item_t it;
    it = noise_item(ACT_SPAWN);
    it.cfg = pick_slot();
    if ($urandom_range(0, 2) != 0) begin
      it.sx = $signed($urandom_range(0, 2000000)) - 1000000;
      it.sy = $signed($urandom_range(0, 2000000)) - 1000000;
      it.svx = $signed($urandom_range(0, 400000)) - 200000;
      it.svy = $signed($urandom_range(0, 400000)) - 200000;
    end
    case ($urandom_range(0, 3))
      0: it.life = 31'($urandom_range(1, 3000));
      1, 2: it.life = 31'($urandom_range(60000, 600000));
      default: ;
    endcase
    return it;
  endfunction

  function automatic item_t rand_tick();
    item_t it;
    it = noise_item(ACT_TICK);
    if ($urandom_range(0, 4) != 0) it.dt = 16'($urandom_range(0, 3000));
    return it;
  endfunction

  // stimulus
  initial begin
    item_t it;
    int    k;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_ticks = 0;
    n_drops = 0;
    n_full = 0;
    pool_n = 0;
    cfg_n = 0;
    cfg_written = 0;
    for (k = 0; k <= NTAB; k++) begin
      longint t, lo, hi, mid;
      t = (longint'(k) * 65536) / NTAB;
      log_lut[k] = frac_log2(65536 + t);
      lo = 65536;
      hi = 131072;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (frac_log2(mid) >= t) hi = mid;
        else lo = mid + 1;
      end
      exp_lut[k] = lo;
    end

    // directed: field extremes, lookup hit, table full, dt extremes, empty tick
    queue_item(noise_item(ACT_CLEAR));
    it = noise_item(ACT_CONFIG);
    it.grav = 32'h7FFF_FFFF; it.damp = 65536; it.streak = 0; it.mode = 0;
    queue_item(it);
    it.grav = 32'h8000_0000; it.damp = 0; it.streak = 16'hFFFF; it.mode = 1;
    queue_item(it);
    it.grav = 32'h7FFF_FFFF; it.damp = 65536; it.streak = 0; it.mode = 0;
    queue_item(it);
    it.grav = 32'hFFF6_0000; it.damp = 131071; it.streak = 16'h1234; it.mode = 1;
    queue_item(it);
    it.grav = 32'h0000_8000; it.damp = 40000; it.streak = 7; it.mode = 0;
    queue_item(it);
    it = noise_item(ACT_SPAWN);
    it.sx = 32'h7FFF_FFFF; it.sy = 32'h8000_0000; it.svx = 32'h7FFF_FFFF;
    it.svy = 32'h8000_0000; it.life = 31'h7FFF_FFFF; it.cfg = 0;
    queue_item(it);
    it.sx = 32'h8000_0000; it.sy = 32'h7FFF_FFFF; it.svx = 32'h8000_0000;
    it.svy = 32'h7FFF_FFFF; it.life = 1; it.cfg = 1;
    queue_item(it);
    it.life = 200000; it.cfg = 2; it.sx = 0; it.svy = 32'h0001_0000;
    queue_item(it);
    it.cfg = 3; it.life = 500000;
    queue_item(it);
    it = noise_item(ACT_TICK); it.dt = 0;
    queue_item(it);
    it.dt = 16'hFFFF;
    queue_item(it);
    it.dt = 1000;
    queue_item(it);
    for (k = 0; k < 5; k++) begin
      it = noise_item(ACT_CONFIG);
      it.damp = 17'(30000 + k);
      queue_item(it);
    end
    queue_item(noise_item(ACT_CLEAR));
    queue_item(rand_tick());
    n_items = item_q.size();

    // random: mostly spawn/tick traffic, one burst that overflows the pool
    k = 0;
    while (k < 150) begin
      if (k == 60) begin
        repeat (NPOOL + 3) queue_item(rand_spawn());
        queue_item(rand_tick());
        k += NPOOL + 4;
      end else begin
        case ($urandom_range(0, 19))
          0, 1: queue_item(rand_config());
          2: queue_item(noise_item(ACT_CLEAR));
          3, 4, 5, 6, 7, 8, 9, 10, 11: queue_item(rand_spawn());
          default: queue_item(rand_tick());
        endcase
        k++;
      end
    end
    n_items += k;
  end

  // driver
  int  send_gap = 0;
  logic item_took;

  initial begin
    rst = 1;
    item_valid = 0;
    res_ready = 0;
    {action, gravity, damping, streak_length, draw_mode} = '0;
    {spawn_x, spawn_y, spawn_vx, spawn_vy, spawn_life, spawn_config, dt} = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) item_took <= !rst && item_valid && item_ready;

  always @(negedge clk) begin
    item_t it;
    if (!rst && !(item_valid && !item_took)) begin
      if (send_gap > 0) begin
        item_valid <= 0;
        send_gap <= send_gap - 1;
      end else if (item_q.size() > 0) begin
        it = item_q.pop_front();
        action <= it.act;
        gravity <= it.grav;
        damping <= it.damp;
        streak_length <= it.streak;
        draw_mode <= it.mode;
        spawn_x <= it.sx;
        spawn_y <= it.sy;
        spawn_vx <= it.svx;
        spawn_vy <= it.svy;
        spawn_life <= it.life;
        spawn_config <= it.cfg;
        dt <= it.dt;
        item_valid <= 1;
        send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      end else item_valid <= 0;
    end
  end

  // receiver: random stalls per result, one long hold-off
  int  recv_wait = 0;
  bit  long_done = 1'b0;
  logic res_took;

  always @(negedge clk) begin
    if (!rst) begin
      if (res_took) begin
        if (!long_done && n_results >= 40) begin
          long_done = 1;
          recv_wait = 400;
        end else recv_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      end
      if (recv_wait > 0) begin
        res_ready <= 0;
        recv_wait--;
      end else res_ready <= 1;
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0h want %0h", n_results, what, got, want);
    errors++;
  endtask

  // monitor
  always @(posedge clk) begin
    result_t w;
    res_took <= !rst && res_valid && res_ready;
    if (!rst && res_valid && res_ready) begin
      if (result_q.size() == 0) begin
        $display("unexpected result %0d", n_results);
        errors++;
      end else begin
        w = result_q.pop_front();
        if (config_slot !== w.slot) report("config_slot", config_slot, w.slot);
        if (table_full !== w.full) report("table_full", table_full, w.full);
        if (accepted !== w.acc) report("accepted", accepted, w.acc);
        if (particle_valid !== w.valid) report("particle_valid", particle_valid, w.valid);
        if (out_x !== w.x) report("out_x", out_x, w.x);
        if (out_y !== w.y) report("out_y", out_y, w.y);
        if (out_life !== w.life) report("out_life", out_life, w.life);
        if (out_config !== w.cfg) report("out_config", out_config, w.cfg);
        if (live_count !== w.count) report("live_count", live_count, w.count);
        if (last !== w.last) report("last", last, w.last);
      end
      n_results++;
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (item_q.size() == 0 && !item_valid && result_q.size() == 0) break;
    end
    repeat (200) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0d expected results never arrived", result_q.size());
      errors++;
    end
    $display("ran %0d items (%0d ticks), checked %0d results", n_items, n_ticks, n_results);
    $display("pool overflow drops %0d, full-table fallbacks %0d, errors %0d",
             n_drops, n_full, errors);
    if (errors == 0) $display("** particle_pool_physics_step_unit: PASSED **");
    else $display("** particle_pool_physics_step_unit: FAILED **");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout waiting for results");
    $display("** particle_pool_physics_step_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/pps_pkg.sv
hw/rtl/pps_ctrl.sv
hw/rtl/pps_dp.sv
hw/rtl/particle_pool_physics_step_unit.sv
hw/rtl/pps_checker.sv
sim/tb.sv
